@@ src/s5c_pkg.sv @@
// Shared types and constants for the SOCKS5 client handshake unit.
// No dependencies; imported by every module of the block.
package s5c_pkg;

    // input word kinds (s_axis_tuser)
    localparam logic [1:0] REQ_CONNECT_OK   = 2'd0;
    localparam logic [1:0] REQ_CONNECT_FAIL = 2'd1;
    localparam logic [1:0] REQ_RX_BYTE      = 2'd2;
    localparam logic [1:0] REQ_CONN_EVENT   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_DEST_IS_IPV6   = 3'd0;
    localparam logic [2:0] CFG_DEST_IPV4_ADDR = 3'd1;
    localparam logic [2:0] CFG_DEST_IPV6_HIGH = 3'd2;
    localparam logic [2:0] CFG_DEST_IPV6_LOW  = 3'd3;
    localparam logic [2:0] CFG_DEST_PORT      = 3'd4;

    // protocol bytes
    localparam logic [7:0] VER_SOCKS5     = 8'h05;
    localparam logic [7:0] METHOD_NO_AUTH = 8'h00;
    localparam logic [7:0] CMD_CONNECT    = 8'h01;
    localparam logic [7:0] REPLY_OK       = 8'h00;
    localparam logic [7:0] RSV_BYTE       = 8'h00;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_IPV6      = 8'h04;
    localparam logic [7:0] NUM_METHODS    = 8'h01;

    // message lengths
    localparam logic [4:0] LEN_NONE        = 5'd0;
    localparam logic [4:0] LEN_SRV_HELLO   = 5'd2;
    localparam logic [4:0] LEN_REPLY_HDR   = 5'd4;
    localparam logic [4:0] LEN_BND_IPV4    = 5'd6;
    localparam logic [4:0] LEN_BND_IPV6    = 5'd18;
    localparam logic [4:0] LEN_HELLO_TX    = 5'd3;
    localparam logic [4:0] LEN_REQ_IPV4_TX = 5'd10;
    localparam logic [4:0] LEN_REQ_IPV6_TX = 5'd22;
    localparam logic [4:0] LEN_SINGLE      = 5'd1;

    typedef enum logic [2:0] {
        PH_CONNECT = 3'd0,
        PH_HELLO   = 3'd1,
        PH_RHDR    = 3'd2,
        PH_RADDR   = 3'd3,
        PH_UP      = 3'd4,
        PH_DEAD    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_UP     = 2'd1,
        KIND_ERR    = 2'd2,
        KIND_CLOSED = 2'd3
    } t_kind;

    // work handed from the front end to the emitter
    typedef enum logic [2:0] {
        CMD_HELLO   = 3'd0,
        CMD_REQUEST = 3'd1,
        CMD_ERROR   = 3'd2,
        CMD_UP      = 3'd3,
        CMD_CLOSED  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic        is_ipv6;
        logic [31:0] ipv4_addr;
        logic [63:0] ipv6_high;
        logic [63:0] ipv6_low;
        logic [15:0] port;
    } t_dest;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ src/socks5_client_handshake_unit.sv @@
// SOCKS5 client handshake unit: commands from accepted words are registered in the
// command queue, result words in the emitter's output stage. One input word per cycle
// while the queue has room; results leave one per cycle while the consumer is ready.
// A hello is 3 words, a request 10 (IPv4) or 22 (IPv6), set by the emitter's byte
// counter. Input stalls only on a full queue. Synchronous active-low reset: phase
// back to awaiting connect, destination registers zero, queue and output stage empty.
module socks5_client_handshake_unit
    import s5c_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_data, [8] event_closed, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_data
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    t_dest     r_dest;
    t_q_status w_q_status;
    logic      w_push;
    t_cmd      w_cmd;
    logic      w_pop;
    t_cmd      w_head;
    t_kind     w_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DEST_IS_IPV6:   r_dest.is_ipv6   <= i_cfg_wdata[0];
                CFG_DEST_IPV4_ADDR: r_dest.ipv4_addr <= i_cfg_wdata[31:0];
                CFG_DEST_IPV6_HIGH: r_dest.ipv6_high <= i_cfg_wdata;
                CFG_DEST_IPV6_LOW:  r_dest.ipv6_low  <= i_cfg_wdata;
                CFG_DEST_PORT:      r_dest.port      <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    s5c_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .i_req_type     (s_axis_tuser),
        .i_rx_data      (s_axis_tdata[7:0]),
        .i_event_closed (s_axis_tdata[8]),
        .i_q_status     (w_q_status),
        .o_ready        (s_axis_tready),
        .o_push         (w_push),
        .o_cmd          (w_cmd)
    );

    s5c_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    s5c_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .i_dest     (r_dest),
        .i_ready    (m_axis_tready),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .o_kind     (w_kind),
        .o_tx_data  (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tuser = w_kind;

endmodule

@@ src/s5c_front.sv @@
// Front end: takes input words, tracks the handshake phase and classifies
// each word into at most one emitter command. Depends on s5c_pkg.
module s5c_front
    import s5c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_rx_data,
    input  logic       i_event_closed,
    input  t_q_status  i_q_status,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase     r_phase,        n_phase;
    logic [4:0] r_byte_count,   n_byte_count;
    logic [4:0] r_msg_len,      n_msg_len;
    logic       r_header_bad,   n_header_bad;

    logic       w_fire;
    logic       w_cmd_valid;
    logic [4:0] w_count_inc;
    logic       w_done;
    logic       w_bad;

    assign o_ready = !i_q_status.full;
    assign w_fire  = i_valid && o_ready;
    assign o_push  = w_fire && w_cmd_valid;

    assign w_count_inc = r_byte_count + 5'd1;
    assign w_done      = (w_count_inc >= r_msg_len);
    assign w_bad       = r_header_bad
                       || ((r_byte_count == 5'd0) && (i_rx_data != VER_SOCKS5))
                       || ((r_byte_count == 5'd1) && (i_rx_data != METHOD_NO_AUTH));

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_msg_len    = r_msg_len;
        n_header_bad = r_header_bad;
        w_cmd_valid  = 1'b0;
        o_cmd        = CMD_ERROR;

        unique case (i_req_type)
            REQ_CONNECT_OK, REQ_CONNECT_FAIL: begin
                if (r_phase == PH_CONNECT) begin
                    w_cmd_valid = 1'b1;
                    if (i_req_type == REQ_CONNECT_FAIL) begin
                        o_cmd   = CMD_ERROR;
                        n_phase = PH_DEAD;
                    end else begin
                        o_cmd        = CMD_HELLO;
                        n_byte_count = 5'd0;
                        n_msg_len    = LEN_SRV_HELLO;
                        n_header_bad = 1'b0;
                        n_phase      = PH_HELLO;
                    end
                end
            end
            REQ_CONN_EVENT: begin
                if (r_phase != PH_CONNECT) begin
                    w_cmd_valid = 1'b1;
                    o_cmd   = (r_phase == PH_UP && i_event_closed) ? CMD_CLOSED : CMD_ERROR;
                    n_phase = PH_DEAD;
                end
            end
            default: begin
                // received byte; only counted in the three receive phases
                if (r_phase == PH_HELLO || r_phase == PH_RHDR || r_phase == PH_RADDR) begin
                    n_byte_count = w_count_inc;
                end
                if (r_phase == PH_HELLO) begin
                    n_header_bad = w_bad;
                    if (w_done) begin
                        w_cmd_valid = 1'b1;
                        if (w_bad) begin
                            o_cmd   = CMD_ERROR;
                            n_phase = PH_DEAD;
                        end else begin
                            o_cmd        = CMD_REQUEST;
                            n_byte_count = 5'd0;
                            n_msg_len    = LEN_REPLY_HDR;
                            n_header_bad = 1'b0;
                            n_phase      = PH_RHDR;
                        end
                    end
                end else if (r_phase == PH_RHDR) begin
                    n_header_bad = w_bad;
                    if (w_done) begin
                        if (w_bad || (i_rx_data != ATYP_IPV4 && i_rx_data != ATYP_IPV6)) begin
                            w_cmd_valid = 1'b1;
                            o_cmd       = CMD_ERROR;
                            n_phase     = PH_DEAD;
                        end else begin
                            n_byte_count = 5'd0;
                            n_msg_len    = (i_rx_data == ATYP_IPV4) ? LEN_BND_IPV4
                                                                    : LEN_BND_IPV6;
                            n_header_bad = 1'b0;
                            n_phase      = PH_RADDR;
                        end
                    end
                end else if (r_phase == PH_RADDR) begin
                    if (w_done) begin
                        w_cmd_valid  = 1'b1;
                        o_cmd        = CMD_UP;
                        n_byte_count = 5'd0;
                        n_msg_len    = LEN_NONE;
                        n_header_bad = 1'b0;
                        n_phase      = PH_UP;
                    end
                end
            end
        endcase

        // dead or undefined phase swallows everything
        if (r_phase != PH_CONNECT && r_phase != PH_HELLO && r_phase != PH_RHDR
                && r_phase != PH_RADDR && r_phase != PH_UP) begin
            n_phase      = PH_DEAD;
            n_byte_count = r_byte_count;
            n_msg_len    = r_msg_len;
            n_header_bad = r_header_bad;
            w_cmd_valid  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CONNECT;
            r_byte_count <= 5'd0;
            r_msg_len    <= LEN_NONE;
            r_header_bad <= 1'b0;
        end else if (w_fire) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_msg_len    <= n_msg_len;
            r_header_bad <= n_header_bad;
        end
    end

endmodule

@@ src/s5c_queue.sv @@
// Short command queue between the front end and the emitter.
// Depends on s5c_pkg for the command type and status struct.
module s5c_queue
    import s5c_pkg::*;
#(
    parameter int P_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cmd          r_mem [P_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_status.full  = (r_count == CW'(P_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign w_do_push = i_push && !o_status.full;
    assign w_do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ src/s5c_back.sv @@
// Emitter: expands each queued command into result words, one per cycle
// when not stalled, into a registered output stage. Depends on s5c_pkg.
module s5c_back
    import s5c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_status  i_q_status,
    input  t_dest      i_dest,
    input  logic       i_ready,
    output logic       o_pop,
    output logic       o_valid,
    output t_kind      o_kind,
    output logic [7:0] o_tx_data,
    output logic       o_last
);

    logic [4:0] r_idx, n_idx;
    logic       r_valid;
    t_kind      r_kind, n_kind;
    logic [7:0] r_data, n_data;
    logic       r_last;

    logic [4:0] w_len;
    logic       w_load;
    logic       w_final;

    // byte idx of the request; the hello is the same first three bytes
    function automatic logic [7:0] request_byte(input logic [4:0] idx, input t_dest d);
        logic [127:0] addr6;
        logic [7:0]   b;
        addr6 = {d.ipv6_high, d.ipv6_low};
        b     = 8'h00;
        if (idx == 5'd0) begin
            b = VER_SOCKS5;
        end else if (idx == 5'd1) begin
            b = CMD_CONNECT;
        end else if (idx == 5'd2) begin
            b = RSV_BYTE;
        end else if (idx == 5'd3) begin
            b = d.is_ipv6 ? ATYP_IPV6 : ATYP_IPV4;
        end else if (d.is_ipv6) begin
            if (idx <= 5'd19) begin
                b = addr6[8 * (5'd19 - idx) +: 8];
            end else if (idx == 5'd20) begin
                b = d.port[15:8];
            end else begin
                b = d.port[7:0];
            end
        end else begin
            if (idx <= 5'd7) begin
                b = d.ipv4_addr[8 * (5'd7 - idx) +: 8];
            end else if (idx == 5'd8) begin
                b = d.port[15:8];
            end else begin
                b = d.port[7:0];
            end
        end
        return b;
    endfunction

    always_comb begin
        unique case (i_head)
            CMD_HELLO:   w_len = LEN_HELLO_TX;
            CMD_REQUEST: w_len = i_dest.is_ipv6 ? LEN_REQ_IPV6_TX : LEN_REQ_IPV4_TX;
            default:     w_len = LEN_SINGLE;
        endcase
    end

    always_comb begin
        n_data = 8'h00;
        unique case (i_head)
            CMD_HELLO: begin
                n_kind = KIND_TX;
                // hello: version, one method, no-auth
                if (r_idx == 5'd0) begin
                    n_data = VER_SOCKS5;
                end else if (r_idx == 5'd1) begin
                    n_data = NUM_METHODS;
                end else begin
                    n_data = METHOD_NO_AUTH;
                end
            end
            CMD_REQUEST: begin
                n_kind = KIND_TX;
                n_data = request_byte(r_idx, i_dest);
            end
            CMD_UP:     n_kind = KIND_UP;
            CMD_CLOSED: n_kind = KIND_CLOSED;
            default:    n_kind = KIND_ERR;
        endcase
    end

    assign w_load  = !i_q_status.empty && (!r_valid || i_ready);
    assign w_final = (r_idx == w_len - 5'd1);
    assign o_pop   = w_load && w_final;
    assign n_idx   = w_final ? 5'd0 : r_idx + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= n_idx;
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= n_kind;
            r_data <= n_data;
            r_last <= w_final;
        end
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_tx_data = r_data;
    assign o_last    = r_last;

endmodule

@@ tb/tb_socks5_client_handshake_unit.sv @@
// Self-checking testbench for socks5_client_handshake_unit: feeds connect results,
// server bytes and link events, predicts every result word and checks them in order.
// Depends on s5c_pkg and the RTL top level; needs no files or arguments.
module tb_socks5_client_handshake_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import s5c_pkg::*;

    localparam int unsigned NUM_ITEMS    = 330;
    localparam int unsigned CLOSE_AT     = 300;     // link event once up, near the end
    localparam int unsigned CYCLE_LIMIT  = 3000000;
    localparam int unsigned QUIET_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES  = 32;
    localparam int unsigned MAX_SHOWN    = 10;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] rx;
        logic       closed;
    } t_sock_event;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result_word;

    // opening rows; typed rows carry their expected tx bytes, first byte lowest
    typedef struct packed {
        t_sock_event ev;
        logic        typed;
        logic [1:0]  n_tx;
        logic [23:0] tx;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // [7:0] rx_data, [8] event_closed, rest zero
    logic [1:0]  s_axis_tuser;     // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // [7:0] tx_data
    logic [1:0]  m_axis_tuser;     // [1:0] kind
    logic        m_axis_tlast;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_wdata;

    // predictor state and its copy of the destination registers
    t_phase      hs_phase  = PH_CONNECT;
    logic [4:0]  rx_count  = '0;
    logic [4:0]  msg_len   = '0;
    logic        hdr_bad   = 1'b0;
    t_dest       model_dest = '0;

    t_result_word pending_words[$];
    t_result_word caused[$];

    int unsigned items_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned fault_count   = 0;
    int unsigned cycles        = 0;
    int unsigned send_calm     = 0;
    int unsigned recv_calm     = 0;
    int unsigned recv_hold     = 0;

    t_script_row opening [8] = '{
        // all ignored while waiting for the connect result
        '{'{REQ_RX_BYTE,      8'h00, 1'b0}, 1'b1, 2'd0, 24'd0},
        '{'{REQ_RX_BYTE,      8'hff, 1'b1}, 1'b1, 2'd0, 24'd0},
        '{'{REQ_RX_BYTE,      8'h5a, 1'b0}, 1'b0, 2'd0, 24'd0},
        '{'{REQ_CONN_EVENT,   8'ha5, 1'b0}, 1'b1, 2'd0, 24'd0},
        '{'{REQ_CONN_EVENT,   8'h00, 1'b1}, 1'b1, 2'd0, 24'd0},
        // connect: client hello goes out
        '{'{REQ_CONNECT_OK,   8'h00, 1'b0}, 1'b1, 2'd3,
          {METHOD_NO_AUTH, NUM_METHODS, VER_SOCKS5}},
        // further connect results are ignored
        '{'{REQ_CONNECT_OK,   8'hff, 1'b1}, 1'b0, 2'd0, 24'd0},
        '{'{REQ_CONNECT_FAIL, 8'h00, 1'b0}, 1'b0, 2'd0, 24'd0}
    };

    always #5 i_clk = ~i_clk;

    socks5_client_handshake_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // mostly short gaps, a few long ones, and now and then a calm stretch with none
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if (r < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void add_word(t_kind kind, logic [7:0] data);
        caused.push_back('{kind, data, 1'b0});
    endfunction

    function automatic void open_message(logic [4:0] len);
        rx_count = '0;
        msg_len  = len;
        hdr_bad  = 1'b0;
    endfunction

    // advance the handshake by one event; the words it causes land in caused
    function automatic void step_handshake(t_sock_event ev);
        logic [4:0] idx;
        logic       done;
        int         b;
        caused.delete();
        if (hs_phase > PH_UP) begin
            hs_phase = PH_DEAD;
            return;
        end
        case (ev.req)
            REQ_CONNECT_OK, REQ_CONNECT_FAIL: begin
                if (hs_phase == PH_CONNECT) begin
                    if (ev.req == REQ_CONNECT_FAIL) begin
                        add_word(KIND_ERR, 8'h00);
                        hs_phase = PH_DEAD;
                    end else begin
                        add_word(KIND_TX, VER_SOCKS5);
                        add_word(KIND_TX, NUM_METHODS);
                        add_word(KIND_TX, METHOD_NO_AUTH);
                        open_message(LEN_SRV_HELLO);
                        hs_phase = PH_HELLO;
                    end
                end
            end
            REQ_CONN_EVENT: begin
                if (hs_phase != PH_CONNECT) begin
                    add_word((hs_phase == PH_UP && ev.closed) ? KIND_CLOSED : KIND_ERR, 8'h00);
                    hs_phase = PH_DEAD;
                end
            end
            default: begin
                if (hs_phase != PH_CONNECT && hs_phase != PH_UP) begin
                    idx      = rx_count;
                    rx_count = rx_count + 5'd1;
                    done     = (rx_count >= msg_len);
                    case (hs_phase)
                        PH_HELLO: begin
                            if ((idx == 0 && ev.rx != VER_SOCKS5) ||
                                (idx == 1 && ev.rx != METHOD_NO_AUTH))
                                hdr_bad = 1'b1;
                            if (done && hdr_bad) begin
                                add_word(KIND_ERR, 8'h00);
                                hs_phase = PH_DEAD;
                            end else if (done) begin
                                // request uses the registers as they are now
                                add_word(KIND_TX, VER_SOCKS5);
                                add_word(KIND_TX, CMD_CONNECT);
                                add_word(KIND_TX, RSV_BYTE);
                                if (model_dest.is_ipv6) begin
                                    add_word(KIND_TX, ATYP_IPV6);
                                    for (b = 7; b >= 0; b--)
                                        add_word(KIND_TX, model_dest.ipv6_high[8*b +: 8]);
                                    for (b = 7; b >= 0; b--)
                                        add_word(KIND_TX, model_dest.ipv6_low[8*b +: 8]);
                                end else begin
                                    add_word(KIND_TX, ATYP_IPV4);
                                    for (b = 3; b >= 0; b--)
                                        add_word(KIND_TX, model_dest.ipv4_addr[8*b +: 8]);
                                end
                                add_word(KIND_TX, model_dest.port[15:8]);
                                add_word(KIND_TX, model_dest.port[7:0]);
                                open_message(LEN_REPLY_HDR);
                                hs_phase = PH_RHDR;
                            end
                        end
                        PH_RHDR: begin
                            // reserved byte is not checked
                            if ((idx == 0 && ev.rx != VER_SOCKS5) ||
                                (idx == 1 && ev.rx != REPLY_OK))
                                hdr_bad = 1'b1;
                            if (done) begin
                                if (hdr_bad || (ev.rx != ATYP_IPV4 && ev.rx != ATYP_IPV6)) begin
                                    add_word(KIND_ERR, 8'h00);
                                    hs_phase = PH_DEAD;
                                end else begin
                                    open_message(ev.rx == ATYP_IPV4 ? LEN_BND_IPV4
                                                                    : LEN_BND_IPV6);
                                    hs_phase = PH_RADDR;
                                end
                            end
                        end
                        default: begin
                            if (done) begin
                                add_word(KIND_UP, 8'h00);
                                open_message(LEN_NONE);
                                hs_phase = PH_UP;
                            end
                        end
                    endcase
                end
            end
        endcase
        if (caused.size() != 0)
            caused[caused.size() - 1].last = 1'b1;
    endfunction

    // mostly a well-formed exchange with random content, some noise and broken bytes
    function automatic t_sock_event pick_event();
        t_sock_event ev;
        int unsigned r;
        r         = $urandom_range(0, 999);
        ev.req    = REQ_RX_BYTE;
        ev.rx     = 8'($urandom);
        ev.closed = 1'($urandom);
        case (hs_phase)
            PH_HELLO, PH_RHDR, PH_RADDR: begin
                if (r < 120) begin
                    ev.req = $urandom_range(0, 1) ? REQ_CONNECT_OK : REQ_CONNECT_FAIL;
                end else if (r < 125) begin
                    ev.req = REQ_CONN_EVENT;        // link drops mid-handshake
                end else if (r < 985 && hs_phase == PH_HELLO) begin
                    ev.rx = (rx_count == 0) ? VER_SOCKS5 : METHOD_NO_AUTH;
                end else if (r < 985 && hs_phase == PH_RHDR) begin
                    case (rx_count)
                        5'd0:    ev.rx = VER_SOCKS5;
                        5'd1:    ev.rx = REPLY_OK;
                        5'd3:    ev.rx = $urandom_range(0, 1) ? ATYP_IPV4 : ATYP_IPV6;
                        default: ;
                    endcase
                end
            end
            PH_UP: begin
                if (items_sent >= CLOSE_AT)
                    ev.req = REQ_CONN_EVENT;
                else if (r >= 700)
                    ev.req = (r < 850) ? REQ_CONNECT_OK : REQ_CONNECT_FAIL;
            end
            default: ev.req = 2'($urandom);
        endcase
        return ev;
    endfunction

    task automatic push_event(t_sock_event ev, logic typed, logic [1:0] n_tx,
                              logic [23:0] tx);
        int unsigned gap;
        int          k;
        gap = pick_gap(send_calm);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev.req;
        s_axis_tdata  <= {7'd0, ev.closed, ev.rx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_handshake(ev);
        if (typed) begin
            for (k = 0; k < n_tx; k++)
                pending_words.push_back('{KIND_TX, tx[8*k +: 8], k == n_tx - 1});
        end else begin
            foreach (caused[j]) pending_words.push_back(caused[j]);
        end
        items_sent++;
    endtask

    // wait until the block has drained, so that register writes land while idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_DEST_IS_IPV6:   model_dest.is_ipv6   = value[0];
            CFG_DEST_IPV4_ADDR: model_dest.ipv4_addr = value[31:0];
            CFG_DEST_IPV6_HIGH: model_dest.ipv6_high = value;
            CFG_DEST_IPV6_LOW:  model_dest.ipv6_low  = value;
            CFG_DEST_PORT:      model_dest.port      = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_dest(t_dest d);
        write_reg(CFG_DEST_IS_IPV6,   64'(d.is_ipv6));
        write_reg(CFG_DEST_IPV4_ADDR, 64'(d.ipv4_addr));
        write_reg(CFG_DEST_IPV6_HIGH, d.ipv6_high);
        write_reg(CFG_DEST_IPV6_LOW,  d.ipv6_low);
        write_reg(CFG_DEST_PORT,      64'(d.port));
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_result_word want;
        int unsigned  gap;
        if (m_axis_tvalid && m_axis_tready) begin
            words_checked++;
            if (pending_words.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_SHOWN)
                    $display("unexpected result word: kind %0d data %02h last %0b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_words.pop_front();
                if (m_axis_tuser != want.kind || m_axis_tdata != want.data ||
                    m_axis_tlast != want.last) begin
                    fault_count++;
                    if (fault_count <= MAX_SHOWN)
                        $display({"result word %0d: expected kind %0d data %02h last %0b,",
                                  " got kind %0d data %02h last %0b"},
                                 words_checked, want.kind, want.data, want.last,
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
            end
        end
        if (recv_hold != 0) begin
            recv_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            gap = pick_gap(recv_calm);
            recv_hold = (gap != 0) ? gap - 1 : 0;
            m_axis_tready <= (gap == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, pending_words.size());
            $display("tb_socks5_client_handshake_unit: FAIL");
            $finish;
        end
    end

    initial begin
        t_dest d;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_CONNECT_OK;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_DEST_IS_IPV6;
        i_cfg_wdata   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_dest('1);
        for (int r = 0; r < $size(opening); r++) begin
            // zero destination just before the connect
            if (r == 5) begin
                settle();
                load_dest('0);
            end
            push_event(opening[r].ev, opening[r].typed, opening[r].n_tx, opening[r].tx);
        end

        // the request goes out with whatever is written now, mid-handshake
        settle();
        d.is_ipv6   = 1'($urandom);
        d.ipv4_addr = 32'(corner_value());
        d.ipv6_high = corner_value();
        d.ipv6_low  = corner_value();
        d.port      = 16'(corner_value());
        load_dest(d);

        while (items_sent < NUM_ITEMS)
            push_event(pick_event(), 1'b0, 2'd0, 24'd0);

        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d input words sent, %0d result words checked, handshake ended in %s",
                 items_sent, words_checked, hs_phase.name());
        $display("request destination %s, port %04h, %0d mismatches",
                 model_dest.is_ipv6 ? "IPv6" : "IPv4", model_dest.port, fault_count);
        if (fault_count == 0 && pending_words.size() == 0)
            $display("tb_socks5_client_handshake_unit: PASS");
        else
            $display("tb_socks5_client_handshake_unit: FAIL");
        $finish;
    end

endmodule
